// File: src/cbta_pkg.sv
// Shared constants and types for the cubic Bezier trajectory axis.
package cbta_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int FRAC_W      = FRAC_BITS + 1;
  localparam int TIME_W      = 16;
  localparam int POINT_W     = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int OUT_TDATA_W = 72;

  localparam logic [FRAC_W-1:0] WEIGHT_ONE = FRAC_W'(1) << FRAC_BITS;

  localparam logic [TIME_W-1:0] DURATION_RESET  = 16'd1000;
  localparam logic [FRAC_W-1:0] RAMP_UP_RESET   = 17'd16384;
  localparam logic [FRAC_W-1:0] RAMP_DOWN_RESET = 17'd49152;

  // quotient bits of the three dividers
  localparam int FRAC_DIV_Q   = FRAC_W;
  localparam int VEL_DIV_Q    = 47;
  localparam int WEIGHT_DIV_Q = FRAC_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_POINT0,
    REG_POINT1,
    REG_POINT2,
    REG_POINT3,
    REG_PATH_DURATION,
    REG_PEAK_WEIGHT,
    REG_RAMP_UP_END,
    REG_RAMP_DOWN_START
  } cfg_reg_t;

endpackage

// File: src/cubic_bezier_trajectory_axis.sv
// Cubic Bezier trajectory axis: position and weighted feedforward velocity per time sample.
// One beat is accepted every cycle, except while the pipeline holds for a waiting result.
// Depth is set by the time-fraction divider (17 stages) and velocity divider (47 stages).
// The whole pipeline holds while a result waits and out_tready is low.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
module cubic_bezier_trajectory_axis (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cbta_pkg::TIME_W-1:0]        in_tdata,   // [15:0] elapsed_ms
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cbta_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [31:0] goal_position,
                                                         // [63:32] velocity_term,
                                                         // [64] weight_valid
  input  logic                               cfg_we,
  input  logic [cbta_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cbta_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int FW      = cbta_pkg::FRAC_W;
  localparam int FQ      = cbta_pkg::FRAC_DIV_Q;
  localparam int VQ      = cbta_pkg::VEL_DIV_Q;
  localparam int WQ      = cbta_pkg::WEIGHT_DIV_Q;
  localparam int LAT     = 1 + FQ + 8 + VQ + 3;
  localparam int POS_DLY = 2 + VQ + 2;
  localparam int W_DLY   = 8 + VQ - 1 - WQ;
  localparam int NEG_DLY = VQ;
  localparam logic [FW-1:0] ONE = cbta_pkg::WEIGHT_ONE;

  function automatic logic [FW-1:0] qmul(input logic [FW-1:0] a, input logic [FW-1:0] b);
    logic [2*FW:0] p;
    p = (2*FW+1)'(a) * (2*FW+1)'(b) + (2*FW+1)'(32768);
    return p[2*FW-2:cbta_pkg::FRAC_BITS];
  endfunction

  // configuration
  logic signed [31:0] point0_r, point1_r, point2_r, point3_r;
  logic [15:0]        dur_r;
  logic [FW-1:0]      peak_r, rup_r, rdn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point0_r <= '0;
      point1_r <= '0;
      point2_r <= '0;
      point3_r <= '0;
      dur_r    <= cbta_pkg::DURATION_RESET;
      peak_r   <= '0;
      rup_r    <= cbta_pkg::RAMP_UP_RESET;
      rdn_r    <= cbta_pkg::RAMP_DOWN_RESET;
    end else if (cfg_we) begin
      case (cbta_pkg::cfg_reg_t'(cfg_addr))
        cbta_pkg::REG_POINT0:          point0_r <= cfg_wdata;
        cbta_pkg::REG_POINT1:          point1_r <= cfg_wdata;
        cbta_pkg::REG_POINT2:          point2_r <= cfg_wdata;
        cbta_pkg::REG_POINT3:          point3_r <= cfg_wdata;
        cbta_pkg::REG_PATH_DURATION:   dur_r    <= cfg_wdata[15:0];
        cbta_pkg::REG_PEAK_WEIGHT:     peak_r   <= cfg_wdata[FW-1:0];
        cbta_pkg::REG_RAMP_UP_END:     rup_r    <= cfg_wdata[FW-1:0];
        cbta_pkg::REG_RAMP_DOWN_START: rdn_r    <= cfg_wdata[FW-1:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        dur_e;
  logic signed [32:0] d1, d2, d3;
  logic               wv;

  assign dur_e = (dur_r == '0) ? 16'd1 : dur_r;
  assign d1 = $signed({point1_r[31], point1_r}) - $signed({point0_r[31], point0_r});
  assign d2 = $signed({point2_r[31], point2_r}) - $signed({point1_r[31], point1_r});
  assign d3 = $signed({point3_r[31], point3_r}) - $signed({point2_r[31], point2_r});
  assign wv = (rup_r != '0) && (rup_r < rdn_r) && (rdn_r < ONE) && (peak_r <= ONE);

  // pipeline control
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // clamp time
  logic [15:0] t1_r, t1_nxt;
  assign t1_nxt = (in_tdata > dur_e) ? dur_e : in_tdata;

  always_ff @(posedge clk) begin
    if (en) t1_r <= t1_nxt;
  end

  // path fraction f = t / duration
  logic [FW-1:0] f_q, g_q;

  cbta_div #(.QW(FQ), .DW(16)) u_frac_div (
    .clk    (clk),
    .en     (en),
    .in_rem ({1'b0, t1_r[15:1]}),
    .in_num ({t1_r[0], 16'b0}),
    .in_div (dur_e),
    .quo    (f_q)
  );

  assign g_q = ONE - f_q;

  // basis products
  logic [FW-1:0] f19_r, g19_r, gg19_r, ff19_r, gf19_r;
  logic          mid19_r, mid19_nxt, up_sel;
  logic [33:0]   wnum_r, wnum_nxt;
  logic [FW-1:0] wdiv_r, wdiv_nxt;

  always_comb begin
    up_sel    = f_q < rup_r;
    mid19_nxt = !up_sel && (f_q < rdn_r);
    wnum_nxt  = (up_sel ? f_q : g_q) * peak_r;
    wdiv_nxt  = up_sel ? rup_r : FW'(ONE - rdn_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f19_r   <= f_q;
      g19_r   <= g_q;
      gg19_r  <= qmul(g_q, g_q);
      ff19_r  <= qmul(f_q, f_q);
      gf19_r  <= qmul(g_q, f_q);
      mid19_r <= mid19_nxt;
      wnum_r  <= wnum_nxt;
      wdiv_r  <= wdiv_nxt;
    end
  end

  logic [16:0] w0_r, w3_r;
  logic [18:0] w1_r, w2_r, da_r, dc_r;
  logic [19:0] db_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w0_r <= qmul(gg19_r, g19_r);
      w1_r <= 19'(qmul(gg19_r, f19_r)) * 19'd3;
      w2_r <= 19'(qmul(g19_r, ff19_r)) * 19'd3;
      w3_r <= qmul(ff19_r, f19_r);
      da_r <= 19'(gg19_r) * 19'd3;
      db_r <= 20'(gf19_r) * 20'd6;
      dc_r <= 19'(ff19_r) * 19'd3;
    end
  end

  logic signed [51:0] m0_r, m1_r, m2_r, m3_r, s01_r, s23_r, psum_r;
  logic signed [53:0] ma_r, mb_r, mc_r, dab_r, dc2_r, dsum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r   <= $signed({1'b0, w0_r}) * point0_r;
      m1_r   <= $signed({1'b0, w1_r}) * point1_r;
      m2_r   <= $signed({1'b0, w2_r}) * point2_r;
      m3_r   <= $signed({1'b0, w3_r}) * point3_r;
      ma_r   <= $signed({1'b0, da_r}) * d1;
      mb_r   <= $signed({1'b0, db_r}) * d2;
      mc_r   <= $signed({1'b0, dc_r}) * d3;
      s01_r  <= m0_r + m1_r;
      s23_r  <= m2_r + m3_r;
      dab_r  <= ma_r + mb_r;
      dc2_r  <= mc_r;
      psum_r <= s01_r + s23_r;
      dsum_r <= dab_r + dc2_r;
    end
  end

  // round to Q16.16
  logic signed [51:0] prnd;
  logic signed [53:0] drnd_full;
  logic signed [31:0] pos24_r, pos24_nxt;
  logic signed [37:0] drnd_r;

  always_comb begin
    prnd      = (psum_r + 52'sd32768) >>> 16;
    drnd_full = (dsum_r + 54'sd32768) >>> 16;
    if (prnd > 52'sd2147483647) begin
      pos24_nxt = 32'sh7FFFFFFF;
    end else if (prnd < -52'sd2147483648) begin
      pos24_nxt = 32'sh80000000;
    end else begin
      pos24_nxt = prnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos24_r <= pos24_nxt;
      drnd_r  <= drnd_full[37:0];
    end
  end

  // scale to per second
  logic signed [47:0] deriv_r, absd;
  logic [46:0]        mag_r, mag_nxt;
  logic               neg26_r;

  always_comb begin
    absd    = deriv_r[47] ? -deriv_r : deriv_r;
    mag_nxt = 47'(absd) + 47'(dur_e >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deriv_r <= drnd_r * 48'sd1000;
      mag_r   <= mag_nxt;
      neg26_r <= deriv_r[47];
    end
  end

  logic [VQ-1:0] q_vel;

  cbta_div #(.QW(VQ), .DW(16)) u_vel_div (
    .clk    (clk),
    .en     (en),
    .in_rem (16'd0),
    .in_num (mag_r),
    .in_div (dur_e),
    .quo    (q_vel)
  );

  // trapezoidal weight
  logic [WQ-1:0] q_w;
  logic          mid_d_r [WQ];
  logic [FW-1:0] w36;
  logic [FW-1:0] wd_r    [W_DLY];

  cbta_div #(.QW(WQ), .DW(FW)) u_weight_div (
    .clk    (clk),
    .en     (en),
    .in_rem (wnum_r[33:17]),
    .in_num (wnum_r[16:0]),
    .in_div (wdiv_r),
    .quo    (q_w)
  );

  assign w36 = mid_d_r[WQ-1] ? peak_r : q_w;

  logic               negd_r [NEG_DLY];
  logic signed [31:0] posd_r [POS_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      mid_d_r[0] <= mid19_r;
      for (int k = 1; k < WQ; k++) mid_d_r[k] <= mid_d_r[k-1];
      wd_r[0] <= w36;
      for (int k = 1; k < W_DLY; k++) wd_r[k] <= wd_r[k-1];
      negd_r[0] <= neg26_r;
      for (int k = 1; k < NEG_DLY; k++) negd_r[k] <= negd_r[k-1];
      posd_r[0] <= pos24_r;
      for (int k = 1; k < POS_DLY; k++) posd_r[k] <= posd_r[k-1];
    end
  end

  // weighted velocity
  logic [40:0] plo_r;
  logic [39:0] phi_r;
  logic [63:0] full_r;
  logic        neg74_r, neg75_r;

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r   <= q_vel[23:0] * wd_r[W_DLY-1];
      phi_r   <= q_vel[VQ-1:24] * wd_r[W_DLY-1];
      neg74_r <= negd_r[NEG_DLY-1];
      full_r  <= {phi_r, 24'b0} + 64'(plo_r);
      neg75_r <= neg74_r;
    end
  end

  logic signed [64:0] v65, vr;
  logic signed [31:0] vsat, vel_nxt;

  always_comb begin
    v65 = neg75_r ? -$signed({1'b0, full_r}) : $signed({1'b0, full_r});
    vr  = (v65 + 65'sd32768) >>> 16;
    if (vr > 65'sd2147483647) begin
      vsat = 32'sh7FFFFFFF;
    end else if (vr < -65'sd2147483648) begin
      vsat = 32'sh80000000;
    end else begin
      vsat = vr[31:0];
    end
    vel_nxt = wv ? vsat : '0;
  end

  logic signed [31:0] out_pos_r, out_vel_r;
  logic               out_wv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_r <= posd_r[POS_DLY-1];
      out_vel_r <= vel_nxt;
      out_wv_r  <= wv;
    end
  end

  assign out_tdata = {7'b0, out_wv_r, out_vel_r, out_pos_r};

`ifndef SYNTHESIS
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[FQ] |-> f_q <= ONE)
    else $error("path fraction above one");

  a_vel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[64] |-> out_tdata[63:32] == 32'd0)
    else $error("velocity not zero with invalid weight settings");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[LAT-2] |=> out_tvalid)
    else $error("beat lost before output register");
`endif

endmodule

// File: src/cbta_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module cbta_div #(
  parameter int QW = cbta_pkg::FRAC_DIV_Q,
  parameter int DW = cbta_pkg::TIME_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_num,
  input  logic [DW-1:0] in_div,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r   [QW];
  logic [QW-1:0] nq_r    [QW];
  logic [DW-1:0] div_r   [QW];
  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] nq_nxt  [QW];
  logic [DW-1:0] div_nxt [QW];
  logic [DW-1:0] rs      [QW];
  logic [QW-1:0] ns      [QW];
  logic [DW:0]   sh      [QW];
  logic          qb      [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rs[k]      = in_rem;
        ns[k]      = in_num;
        div_nxt[k] = in_div;
      end else begin
        rs[k]      = rem_r[k-1];
        ns[k]      = nq_r[k-1];
        div_nxt[k] = div_r[k-1];
      end
      sh[k] = {rs[k], ns[k][QW-1]};
      if (sh[k] >= {1'b0, div_nxt[k]}) begin
        rem_nxt[k] = DW'(sh[k] - {1'b0, div_nxt[k]});
        qb[k]      = 1'b1;
      end else begin
        rem_nxt[k] = sh[k][DW-1:0];
        qb[k]      = 1'b0;
      end
      nq_nxt[k] = {ns[k][QW-2:0], qb[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k] <= rem_nxt[k];
        nq_r[k]  <= nq_nxt[k];
        div_r[k] <= div_nxt[k];
      end
    end
  end

  assign quo = nq_r[QW-1];

endmodule

// File: tb/sv/tb_cubic_bezier_trajectory_axis.sv
// Testbench for the cubic Bezier trajectory axis: directed and random samples against a predictor.
module tb_cubic_bezier_trajectory_axis;

  localparam int LATENCY = 76;

  typedef struct packed {
    logic        wvalid;
    logic [31:0] vel;
    logic [31:0] pos;
  } axis_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [cbta_pkg::TIME_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [cbta_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [cbta_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [cbta_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic signed [31:0] pt0, pt1, pt2, pt3;
  logic [15:0] dur_ms;
  logic [16:0] peak, up_end, down_start;

  axis_result_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  cubic_bezier_trajectory_axis u_dut (.*);

  always #4 clk = ~clk;

  function automatic longint round_half_up(longint v, int s);
    longint h;
    longint m;
    h = longint'(1) << (s - 1);
    if (v >= 0) return (v + h) >>> s;
    m = -v;
    if (m <= h) return 0;
    return -((m - h + (longint'(1) << s) - 1) >>> s);
  endfunction

  function automatic longint q16_mul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic axis_result_t bezier_sample(logic [15:0] elapsed);
    axis_result_t r;
    longint d, t, f, g, gg, ff, gf, pos, dsum, deriv, mag, persec, w, vel;
    logic ok;
    d = (dur_ms == 0) ? 1 : dur_ms;
    t = elapsed;
    if (t > d) t = d;
    f = (t << 16) / d;
    g = 65536 - f;
    gg = q16_mul(g, g);
    ff = q16_mul(f, f);
    gf = q16_mul(g, f);
    pos = q16_mul(gg, g) * pt0 + 3 * q16_mul(gg, f) * pt1
        + 3 * q16_mul(g, ff) * pt2 + q16_mul(ff, f) * pt3;
    pos = round_half_up(pos, 16);
    ok = up_end > 0 && up_end < down_start && down_start < 65536 && peak <= 65536;
    vel = 0;
    if (ok) begin
      dsum = 3 * gg * (longint'(pt1) - pt0) + 6 * gf * (longint'(pt2) - pt1)
           + 3 * ff * (longint'(pt3) - pt2);
      deriv = round_half_up(dsum, 16) * 1000;
      mag = deriv < 0 ? -deriv : deriv;
      persec = (mag + d / 2) / d;
      if (deriv < 0) persec = -persec;
      if (f < up_end) w = (f * peak) / up_end;
      else if (f < down_start) w = peak;
      else w = (g * peak) / (65536 - down_start);
      vel = round_half_up(persec * w, 16);
    end
    r.pos = clamp32(pos);
    r.vel = clamp32(vel);
    r.wvalid = ok;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    axis_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[64:0];
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.pos !== want.pos) begin
          $error("goal_position expected %0d got %0d", $signed(want.pos), $signed(got.pos));
          errors++;
        end
        if (got.vel !== want.vel) begin
          $error("velocity_term expected %0d got %0d", $signed(want.vel), $signed(got.vel));
          errors++;
        end
        if (got.wvalid !== want.wvalid) begin
          $error("weight_valid expected %0b got %0b", want.wvalid, got.wvalid);
          errors++;
        end
      end
    end
  end

  task automatic send_sample(logic [15:0] elapsed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= elapsed;
    expected_q.push_back(bezier_sample(elapsed));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(cbta_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      cbta_pkg::REG_POINT0: pt0 = val;
      cbta_pkg::REG_POINT1: pt1 = val;
      cbta_pkg::REG_POINT2: pt2 = val;
      cbta_pkg::REG_POINT3: pt3 = val;
      cbta_pkg::REG_PATH_DURATION: dur_ms = val[15:0];
      cbta_pkg::REG_PEAK_WEIGHT: peak = val[16:0];
      cbta_pkg::REG_RAMP_UP_END: up_end = val[16:0];
      cbta_pkg::REG_RAMP_DOWN_START: down_start = val[16:0];
      default: ;
    endcase
  endtask

  task automatic load_path(logic [31:0] p0, p1, p2, p3, logic [15:0] d,
                           logic [16:0] pk, up, dn);
    drain();
    write_reg(cbta_pkg::REG_POINT0, p0);
    write_reg(cbta_pkg::REG_POINT1, p1);
    write_reg(cbta_pkg::REG_POINT2, p2);
    write_reg(cbta_pkg::REG_POINT3, p3);
    write_reg(cbta_pkg::REG_PATH_DURATION, {16'd0, d});
    write_reg(cbta_pkg::REG_PEAK_WEIGHT, {15'd0, pk});
    write_reg(cbta_pkg::REG_RAMP_UP_END, {15'd0, up});
    write_reg(cbta_pkg::REG_RAMP_DOWN_START, {15'd0, dn});
  endtask

  task automatic test_reset_defaults;
    send_sample(16'd0);
    send_sample(16'd500);
    send_sample(16'hffff);
  endtask

  task automatic test_directed_edges;
    load_path(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              16'd0, 17'd65536, 17'd1, 17'd65535);
    send_sample(16'd0);
    send_sample(16'd1);
    send_sample(16'hffff);
    load_path(32'h0001_0000, 32'h0010_0000, 32'hfff0_0000, 32'h0020_0000,
              16'hffff, 17'd65536, 17'd16384, 17'd49152);
    send_sample(16'd0);
    send_sample(16'd16384);
    send_sample(16'd32768);
    send_sample(16'd49151);
    send_sample(16'hfffe);
    send_sample(16'hffff);
    // invalid weight settings: up zero, up not below down, down at one, peak above one
    load_path(32'h0000_1000, 32'h0003_0000, 32'h0005_0000, 32'h0009_0000,
              16'd100, 17'd65536, 17'd0, 17'd40000);
    send_sample(16'd50);
    drain();
    write_reg(cbta_pkg::REG_RAMP_UP_END, 32'd40000);
    send_sample(16'd50);
    drain();
    write_reg(cbta_pkg::REG_RAMP_UP_END, 32'd100);
    write_reg(cbta_pkg::REG_RAMP_DOWN_START, 32'd65536);
    send_sample(16'd50);
    drain();
    write_reg(cbta_pkg::REG_RAMP_DOWN_START, 32'd60000);
    write_reg(cbta_pkg::REG_PEAK_WEIGHT, 32'h1ffff);
    send_sample(16'd50);
    drain();
    write_reg(cbta_pkg::REG_PEAK_WEIGHT, 32'hffff_ffff);
    send_sample(16'd80);
    send_sample(16'd200);
  endtask

  task automatic test_random_paths(int n_items);
    int i;
    for (i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ((i / 40) % 4)
          0: begin send_idle_pct = 0; recv_stall_pct = 0; end
          1: begin send_idle_pct = 55; recv_stall_pct = 0; end
          2: begin send_idle_pct = 0; recv_stall_pct = 55; end
          default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
        load_path($urandom(), $urandom(), $urandom(), $urandom(),
                  ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(2000)),
                  17'($urandom_range(65536)),
                  ($urandom_range(7) == 0) ? 17'($urandom()) : 17'($urandom_range(1, 30000)),
                  ($urandom_range(7) == 0) ? 17'($urandom()) : 17'($urandom_range(30001, 65535)));
      end
      if ($urandom_range(5) == 0) send_sample(16'($urandom()));
      else send_sample(16'($urandom_range(dur_ms + 2)));
    end
  endtask

  initial begin
    pt0 = 0; pt1 = 0; pt2 = 0; pt3 = 0;
    dur_ms = cbta_pkg::DURATION_RESET;
    peak = '0;
    up_end = cbta_pkg::RAMP_UP_RESET;
    down_start = cbta_pkg::RAMP_DOWN_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_edges();
    test_random_paths(400);
    drain();
    $display("Ran %0d result beats over directed edges and random Bezier paths,", results_seen);
    $display("with sender gaps, receiver stalls and invalid weight settings.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
